>>> hdl/cts_pkg.sv
// Package for the cooperative thread scheduler.
// Holds the table size, the event and status codes and the item types.
// No dependencies.
package cts_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int RUN_SLOT_W = 4;
    localparam int ID_W       = 32;

    typedef enum logic [1:0] {
        ACT_CREATE,
        ACT_EXIT,
        ACT_JOIN,
        ACT_YIELD
    } t_action;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NOT_MAIN,
        ST_FULL,
        ST_NO_CHILD,
        ST_BLOCKED,
        ST_NONE_RUNNABLE
    } t_status;

    typedef enum logic [1:0] {
        MODE_RUNNING,
        MODE_RUNNABLE,
        MODE_WAITING,
        MODE_FINISHED
    } t_mode;

    typedef struct packed {
        logic [1:0]      action;
        logic [ID_W-1:0] target_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            status;
        logic [ID_W-1:0]       new_id;
        logic [RUN_SLOT_W-1:0] running_slot;
        logic [ID_W-1:0]       running_id;
        logic                  join_done;
    } t_out_item;

endpackage

>>> hdl/cooperative_thread_scheduler.sv
// Cooperative thread scheduler: thread table, event sequencer and result register.
// Depends on cts_pkg.

// Each accepted item (create, exit, join or yield) is worked off by a small
// sequencer that visits one table slot per cycle through a single slot index
// and a single thread-id memory read port; events rejected at decode skip the
// scans, while a join can scan the table and then do a round-robin pick over
// all slots. The input stalls until the result is in the output register.
// The result may wait there while the next item is taken.
// Thread ids live in a SLOTS-deep memory; reads of slot 0 always return the main id 1.
module cooperative_thread_scheduler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cts_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cts_pkg::t_out_item  o_out_item
);
    import cts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CREATE_SCAN,
        S_EXIT_RD,
        S_EXIT_CHK,
        S_JOIN_SCAN,
        S_JOIN_HIT,
        S_YIELD_CHK,
        S_PICK,
        S_RUN_RD,
        S_RESULT
    } t_state;

    t_state              r_state;
    t_action             r_action;
    logic [ID_W-1:0]     r_target;
    t_status             r_status;
    logic [ID_W-1:0]     r_new_id;
    logic                r_reaped;

    t_mode               r_mode [SLOTS];
    logic                r_slot_reaped [SLOTS];
    logic [ID_W-1:0]     r_wait_id;
    logic [CNT_W-1:0]    r_in_use;
    logic [SLOT_W-1:0]   r_cur;
    logic [ID_W-1:0]     r_next_id;
    logic                r_pending;
    logic [SLOT_W-1:0]   r_join_slot;

    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_steps;
    logic                r_rd_vld;
    logic [SLOT_W-1:0]   r_rd_idx;

    logic                r_out_valid;
    t_out_item           r_out_item;

    // Thread-id memory
    logic [ID_W-1:0]     r_id_mem [SLOTS];
    logic [ID_W-1:0]     r_rdata;
    logic                r_rd_zero;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [ID_W-1:0]     mem_wdata;
    logic [SLOT_W-1:0]   mem_raddr;

    logic [SLOT_W-1:0]   w_idx;
    t_mode               w_mode;
    logic [ID_W-1:0]     w_rd_id;
    logic                w_in_range;
    logic                w_create_hit;
    logic                w_has_room;
    logic                w_pick_hit;
    logic                w_pick_reap;
    logic [CNT_W-1:0]    w_cur_inc;
    logic [CNT_W-1:0]    w_pick_start;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic [CNT_W-1:0]    w_cnt_wrap;
    logic [ID_W-1:0]     w_next_id_inc;
    logic                w_out_free;

    assign w_idx        = r_cnt[SLOT_W-1:0];
    assign w_mode       = r_mode[w_idx];
    assign w_rd_id      = r_rd_zero ? ID_W'(1) : r_rdata;
    assign w_in_range   = (r_cnt < r_in_use);
    assign w_create_hit = (w_mode == MODE_FINISHED) && r_slot_reaped[w_idx];
    assign w_has_room   = (r_in_use < CNT_W'(SLOTS));
    assign w_pick_hit   = (w_mode == MODE_RUNNABLE);
    assign w_pick_reap  = w_pick_hit && (w_idx == '0) && r_pending;
    assign w_cur_inc    = CNT_W'(r_cur) + CNT_W'(1);
    assign w_pick_start = (w_cur_inc == r_in_use) ? '0 : w_cur_inc;
    assign w_cnt_inc    = r_cnt + CNT_W'(1);
    assign w_cnt_wrap   = (w_cnt_inc == r_in_use) ? '0 : w_cnt_inc;
    assign w_next_id_inc = r_next_id + ID_W'(1);
    assign w_out_free   = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Memory port control: one write and one read address per cycle.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = w_idx;
        mem_wdata = '0;
        mem_raddr = w_idx;
        case (r_state)
            S_CREATE_SCAN: begin
                if (w_in_range) begin
                    if (w_create_hit) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_next_id;
                    end
                end else if (w_has_room) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_in_use[SLOT_W-1:0];
                    mem_wdata = r_next_id;
                end
            end
            S_JOIN_HIT: begin
                mem_we = (w_mode == MODE_FINISHED);
            end
            S_PICK: begin
                mem_we    = w_pick_reap;
                mem_waddr = r_join_slot;
            end
            // The running slot stays addressed while the result waits for the output.
            S_EXIT_RD, S_RUN_RD, S_RESULT: begin
                mem_raddr = r_cur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_id_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata   <= r_id_mem[mem_raddr];
        r_rd_zero <= (mem_raddr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            for (int i = 0; i < SLOTS; i++) begin
                r_mode[i]        <= (i == 0) ? MODE_RUNNING : MODE_FINISHED;
                r_slot_reaped[i] <= 1'b0;
            end
            r_wait_id   <= '0;
            r_in_use    <= CNT_W'(1);
            r_cur       <= '0;
            r_next_id   <= ID_W'(2);
            r_pending   <= 1'b0;
            r_join_slot <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_action <= t_action'(i_in_item.action);
                        r_target <= i_in_item.target_id;
                        r_status <= ST_OK;
                        r_new_id <= '0;
                        r_reaped <= 1'b0;
                        r_state  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (r_action)
                        ACT_CREATE: begin
                            if (r_cur != '0) begin
                                r_status <= ST_NOT_MAIN;
                                r_state  <= S_RUN_RD;
                            end else begin
                                r_cnt   <= CNT_W'(1);
                                r_state <= S_CREATE_SCAN;
                            end
                        end
                        ACT_EXIT: begin
                            if (r_cur == '0) begin
                                r_status <= ST_NOT_MAIN;
                                r_state  <= S_RUN_RD;
                            end else begin
                                r_mode[r_cur] <= MODE_FINISHED;
                                r_state       <= S_EXIT_RD;
                            end
                        end
                        ACT_JOIN: begin
                            if (r_cur != '0) begin
                                r_status <= ST_NOT_MAIN;
                                r_state  <= S_RUN_RD;
                            end else if (r_target < ID_W'(2)) begin
                                r_status <= ST_NO_CHILD;
                                r_state  <= S_RUN_RD;
                            end else begin
                                r_cnt    <= CNT_W'(1);
                                r_rd_vld <= 1'b0;
                                r_state  <= S_JOIN_SCAN;
                            end
                        end
                        default: begin
                            r_cnt   <= CNT_W'(r_cur);
                            r_state <= S_YIELD_CHK;
                        end
                    endcase
                end
                S_CREATE_SCAN: begin
                    if (w_in_range) begin
                        if (w_create_hit) begin
                            r_mode[w_idx]        <= MODE_RUNNABLE;
                            r_slot_reaped[w_idx] <= 1'b0;
                            r_new_id             <= r_next_id;
                            r_next_id <= (w_next_id_inc < ID_W'(2)) ? ID_W'(2) : w_next_id_inc;
                            r_state              <= S_RUN_RD;
                        end else begin
                            r_cnt <= w_cnt_inc;
                        end
                    end else if (w_has_room) begin
                        r_mode[r_in_use[SLOT_W-1:0]]        <= MODE_RUNNABLE;
                        r_slot_reaped[r_in_use[SLOT_W-1:0]] <= 1'b0;
                        r_in_use  <= r_in_use + CNT_W'(1);
                        r_new_id  <= r_next_id;
                        r_next_id <= (w_next_id_inc < ID_W'(2)) ? ID_W'(2) : w_next_id_inc;
                        r_state   <= S_RUN_RD;
                    end else begin
                        r_status <= ST_FULL;
                        r_state  <= S_RUN_RD;
                    end
                end
                S_EXIT_RD: begin
                    r_state <= S_EXIT_CHK;
                end
                S_EXIT_CHK: begin
                    // Wake main if it waits on the thread that just exited.
                    if (r_mode[0] == MODE_WAITING && r_wait_id == w_rd_id) begin
                        r_mode[0] <= MODE_RUNNABLE;
                    end
                    r_cnt   <= w_pick_start;
                    r_steps <= CNT_W'(1);
                    r_state <= S_PICK;
                end
                S_JOIN_SCAN: begin
                    // Reads are issued one slot ahead of the compare.
                    if (r_rd_vld && r_rdata == r_target) begin
                        r_cnt    <= CNT_W'(r_rd_idx);
                        r_rd_vld <= 1'b0;
                        r_state  <= S_JOIN_HIT;
                    end else if (w_in_range) begin
                        r_rd_idx <= w_idx;
                        r_rd_vld <= 1'b1;
                        r_cnt    <= w_cnt_inc;
                    end else begin
                        r_rd_vld <= 1'b0;
                        r_status <= ST_NO_CHILD;
                        r_state  <= S_RUN_RD;
                    end
                end
                S_JOIN_HIT: begin
                    if (w_mode == MODE_FINISHED) begin
                        r_slot_reaped[w_idx] <= 1'b1;
                        r_mode[0]            <= MODE_RUNNING;
                        r_wait_id            <= '0;
                        r_reaped             <= 1'b1;
                        r_state              <= S_RUN_RD;
                    end else begin
                        r_mode[0]   <= MODE_WAITING;
                        r_wait_id   <= r_target;
                        r_pending   <= 1'b1;
                        r_join_slot <= w_idx;
                        r_cnt       <= w_pick_start;
                        r_steps     <= CNT_W'(1);
                        r_state     <= S_PICK;
                    end
                end
                S_YIELD_CHK: begin
                    if (w_mode == MODE_RUNNING) begin
                        r_mode[w_idx] <= MODE_RUNNABLE;
                    end
                    r_cnt   <= w_pick_start;
                    r_steps <= CNT_W'(1);
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (w_pick_hit) begin
                        r_cur         <= w_idx;
                        r_mode[w_idx] <= MODE_RUNNING;
                        if (w_pick_reap) begin
                            // Main resumes from its join: the child is reaped now.
                            r_slot_reaped[r_join_slot] <= 1'b1;
                            r_mode[r_join_slot]        <= MODE_FINISHED;
                            r_wait_id                  <= '0;
                            r_pending                  <= 1'b0;
                            r_reaped                   <= 1'b1;
                        end
                        if (r_action == ACT_JOIN && !w_pick_reap) begin
                            r_status <= ST_BLOCKED;
                        end else begin
                            r_status <= ST_OK;
                        end
                        r_state <= S_RUN_RD;
                    end else if (r_steps == r_in_use) begin
                        r_status <= ST_NONE_RUNNABLE;
                        r_state  <= S_RUN_RD;
                    end else begin
                        r_cnt   <= w_cnt_wrap;
                        r_steps <= r_steps + CNT_W'(1);
                    end
                end
                S_RUN_RD: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_item.status       <= r_status;
                        r_out_item.new_id       <= r_new_id;
                        r_out_item.running_slot <= RUN_SLOT_W'(r_cur);
                        r_out_item.running_id   <= w_rd_id;
                        r_out_item.join_done    <= r_reaped;
                        r_out_valid             <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> verif/tb_cooperative_thread_scheduler.sv
// Self-checking testbench for the cooperative thread scheduler.
// Drives create, exit, join and yield items and checks each result against a fixed expected value or a local model.
// Depends on cts_pkg and cooperative_thread_scheduler.
module tb_cooperative_thread_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam int RANDOM_EVENTS = 1150;
    localparam int HOLD_AT_EVENT = 600;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 60;

    typedef struct packed {
        t_action         act;
        logic [ID_W-1:0] target;
        logic [4:0]      reps;
        logic            typed;
        t_out_item       want;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Local copy of the thread table and scheduler registers.
    t_mode           thr_mode   [SLOTS];
    bit              thr_reaped [SLOTS];
    logic [ID_W-1:0] thr_id     [SLOTS];
    logic [ID_W-1:0] wait_id;
    logic [ID_W-1:0] next_id;
    int              used;
    int              run_slot;
    bit              join_wait;
    int              join_child;
    bit              reaped_now;

    t_out_item due_outcomes [$];
    t_dir_row  dir_rows [$];
    int        n_errors = 0;
    int        n_sent   = 0;
    bit        calm     = 1'b0;
    bit        hold_req = 1'b0;

    cooperative_thread_scheduler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void reset_table();
        for (int i = 0; i < SLOTS; i++) begin
            thr_mode[i]   = MODE_FINISHED;
            thr_reaped[i] = 1'b0;
            thr_id[i]     = '0;
        end
        thr_mode[0] = MODE_RUNNING;
        thr_id[0]   = 1;
        wait_id     = '0;
        used        = 1;
        run_slot    = 0;
        next_id     = 2;
        join_wait   = 1'b0;
        join_child  = 0;
    endfunction

    function automatic void reap_thread(int s);
        thr_reaped[s] = 1'b1;
        thr_id[s]     = '0;
        thr_mode[s]   = MODE_FINISHED;
        thr_mode[0]   = MODE_RUNNING;
        wait_id       = '0;
    endfunction

    // Round-robin search starting after the running slot; selecting main while
    // a join is outstanding finishes that join.
    function automatic bit pick_runnable();
        int idx;
        for (int j = 1; j <= used; j++) begin
            idx = (run_slot + j) % used;
            if (thr_mode[idx] == MODE_RUNNABLE) begin
                run_slot      = idx;
                thr_mode[idx] = MODE_RUNNING;
                if (idx == 0 && join_wait) begin
                    reap_thread(join_child);
                    join_wait  = 1'b0;
                    reaped_now = 1'b1;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out_item schedule_event(t_in_item it);
        t_out_item       r;
        t_status         st;
        logic [ID_W-1:0] nid;
        int              idx;
        int              cidx;
        st         = ST_OK;
        nid        = '0;
        reaped_now = 1'b0;
        case (it.action)
            ACT_CREATE: begin
                if (run_slot != 0) begin
                    st = ST_NOT_MAIN;
                end else begin
                    idx = SLOTS;
                    for (int i = 1; i < used; i++)
                        if (idx == SLOTS && thr_mode[i] == MODE_FINISHED && thr_reaped[i])
                            idx = i;
                    if (idx == SLOTS) begin
                        if (used >= SLOTS) begin
                            st = ST_FULL;
                        end else begin
                            idx  = used;
                            used = used + 1;
                        end
                    end
                    if (st == ST_OK) begin
                        thr_id[idx]     = next_id;
                        nid             = next_id;
                        next_id         = next_id + 1;
                        if (next_id < 2)
                            next_id = 2;
                        thr_mode[idx]   = MODE_RUNNABLE;
                        thr_reaped[idx] = 1'b0;
                    end
                end
            end
            ACT_EXIT: begin
                if (run_slot == 0) begin
                    st = ST_NOT_MAIN;
                end else begin
                    thr_mode[run_slot] = MODE_FINISHED;
                    if (thr_mode[0] == MODE_WAITING && wait_id == thr_id[run_slot])
                        thr_mode[0] = MODE_RUNNABLE;
                    if (!pick_runnable())
                        st = ST_NONE_RUNNABLE;
                end
            end
            ACT_JOIN: begin
                if (run_slot != 0) begin
                    st = ST_NOT_MAIN;
                end else if (it.target_id < 2) begin
                    st = ST_NO_CHILD;
                end else begin
                    cidx = SLOTS;
                    for (int i = 0; i < used; i++)
                        if (cidx == SLOTS && thr_id[i] == it.target_id)
                            cidx = i;
                    if (cidx == SLOTS || cidx == 0) begin
                        st = ST_NO_CHILD;
                    end else if (thr_mode[cidx] == MODE_FINISHED) begin
                        reap_thread(cidx);
                        reaped_now = 1'b1;
                    end else begin
                        thr_mode[0] = MODE_WAITING;
                        wait_id     = it.target_id;
                        join_wait   = 1'b1;
                        join_child  = cidx;
                        if (pick_runnable())
                            st = reaped_now ? ST_OK : ST_BLOCKED;
                        else
                            st = ST_NONE_RUNNABLE;
                    end
                end
            end
            default: begin
                if (thr_mode[run_slot] == MODE_RUNNING)
                    thr_mode[run_slot] = MODE_RUNNABLE;
                if (!pick_runnable())
                    st = ST_NONE_RUNNABLE;
            end
        endcase
        r.status       = st;
        r.new_id       = nid;
        r.running_slot = RUN_SLOT_W'(run_slot);
        r.running_id   = thr_id[run_slot];
        r.join_done    = reaped_now;
        return r;
    endfunction

    // Mostly sensible calls for whoever is running, with some rejected ones mixed in.
    function automatic t_in_item random_event();
        t_in_item it;
        int       r;
        it.target_id = $urandom;
        r = $urandom_range(0, 99);
        if (run_slot == 0) begin
            if (r < 35) begin
                it.action = ACT_CREATE;
            end else if (r < 70) begin
                it.action = ACT_JOIN;
                if (used > 1)
                    it.target_id = thr_id[$urandom_range(1, used - 1)];
            end else if (r < 78) begin
                it.action    = ACT_JOIN;
                it.target_id = $urandom_range(0, next_id + 1);
            end else if (r < 82) begin
                it.action = ACT_JOIN;
            end else if (r < 95) begin
                it.action = ACT_YIELD;
            end else begin
                it.action = ACT_EXIT;
            end
        end else begin
            if (r < 45)
                it.action = ACT_YIELD;
            else if (r < 88)
                it.action = ACT_EXIT;
            else if (r < 94)
                it.action = ACT_CREATE;
            else
                it.action = ACT_JOIN;
        end
        return it;
    endfunction

    task automatic offer_event(t_in_item it, bit typed, t_out_item want);
        int        gap;
        int        r;
        t_in_item  noise;
        t_out_item predicted;
        calm = (n_sent >= 300 && n_sent < 400) || (n_sent >= 800 && n_sent < 900);
        if (n_sent == HOLD_AT_EVENT)
            hold_req = 1'b1;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            gap = 0;
        else if (r < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            noise.action    = 2'($urandom);
            noise.target_id = $urandom;
            i_in_valid <= 1'b0;
            i_in_item  <= noise;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = schedule_event(it);
        due_outcomes.push_back(typed ? want : predicted);
        n_sent++;
        @(negedge i_clk);
    endtask

    initial begin : sender
        t_in_item it;
        reset_table();
        dir_rows.push_back('{ACT_YIELD, 32'h0, 5'd1, 1'b1, '{ST_OK, 32'd0, 4'd0, 32'd1, 1'b0}});
        dir_rows.push_back('{ACT_EXIT, 32'hFFFF_FFFF, 5'd1, 1'b1,
                             '{ST_NOT_MAIN, 32'd0, 4'd0, 32'd1, 1'b0}});
        dir_rows.push_back('{ACT_JOIN, 32'h0, 5'd1, 1'b1,
                             '{ST_NO_CHILD, 32'd0, 4'd0, 32'd1, 1'b0}});
        dir_rows.push_back('{ACT_JOIN, 32'h1, 5'd1, 1'b1,
                             '{ST_NO_CHILD, 32'd0, 4'd0, 32'd1, 1'b0}});
        dir_rows.push_back('{ACT_JOIN, 32'hFFFF_FFFF, 5'd1, 1'b1,
                             '{ST_NO_CHILD, 32'd0, 4'd0, 32'd1, 1'b0}});
        dir_rows.push_back('{ACT_CREATE, 32'h0, 5'd1, 1'b1, '{ST_OK, 32'd2, 4'd0, 32'd1, 1'b0}});
        dir_rows.push_back('{ACT_CREATE, 32'hFFFF_FFFF, 5'd1, 1'b1,
                             '{ST_OK, 32'd3, 4'd0, 32'd1, 1'b0}});
        // Main blocks on a live child, then the children misbehave and take turns.
        dir_rows.push_back('{ACT_JOIN, 32'd2, 5'd1, 1'b0, '0});
        dir_rows.push_back('{ACT_CREATE, 32'h0, 5'd1, 1'b0, '0});
        dir_rows.push_back('{ACT_JOIN, 32'd3, 5'd1, 1'b0, '0});
        dir_rows.push_back('{ACT_YIELD, 32'h0, 5'd1, 1'b0, '0});
        // An unrelated child exits, then the awaited one, so main is picked and reaps.
        dir_rows.push_back('{ACT_EXIT, 32'h0, 5'd1, 1'b0, '0});
        dir_rows.push_back('{ACT_EXIT, 32'h0, 5'd1, 1'b0, '0});
        dir_rows.push_back('{ACT_JOIN, 32'd3, 5'd1, 1'b0, '0});
        dir_rows.push_back('{ACT_JOIN, 32'd3, 5'd1, 1'b0, '0});
        // Reuse both reaped slots, fill the table, then one create too many.
        dir_rows.push_back('{ACT_CREATE, 32'h0, 5'd15, 1'b0, '0});
        dir_rows.push_back('{ACT_CREATE, 32'h0, 5'd1, 1'b0, '0});
        dir_rows.push_back('{ACT_YIELD, 32'h0, 5'd16, 1'b0, '0});

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            for (int n = 0; n < dir_rows[k].reps; n++) begin
                it.action    = dir_rows[k].act;
                it.target_id = dir_rows[k].target;
                offer_event(it, dir_rows[k].typed, dir_rows[k].want);
            end
        end
        for (int n = 0; n < RANDOM_EVENTS; n++)
            offer_event(random_event(), 1'b0, '0);

        i_in_valid <= 1'b0;
        while (due_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall runs, quiet stretches, and one long hold-off
    // that backs the block up into its input.
    initial begin : receiver
        int  n;
        int  r;
        logic s;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    s = 1'b0;
                    n = $urandom_range(1, 8);
                end else if (r < 95) begin
                    s = 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    s = 1'b1;
                    n = $urandom_range(20, 60);
                end
                i_out_stall <= s;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_outcome
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_outcomes.size() == 0) begin
                $display("%0t: result with none expected, got %p", $time, o_out_item);
                n_errors++;
            end else begin
                want = due_outcomes.pop_front();
                if (o_out_item.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, o_out_item.status);
                    n_errors++;
                end
                if (o_out_item.new_id !== want.new_id) begin
                    $display("%0t: new_id expected %0h got %0h",
                             $time, want.new_id, o_out_item.new_id);
                    n_errors++;
                end
                if (o_out_item.running_slot !== want.running_slot) begin
                    $display("%0t: running_slot expected %0d got %0d",
                             $time, want.running_slot, o_out_item.running_slot);
                    n_errors++;
                end
                if (o_out_item.running_id !== want.running_id) begin
                    $display("%0t: running_id expected %0h got %0h",
                             $time, want.running_id, o_out_item.running_id);
                    n_errors++;
                end
                if (o_out_item.join_done !== want.join_done) begin
                    $display("%0t: join_done expected %0b got %0b",
                             $time, want.join_done, o_out_item.join_done);
                    n_errors++;
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
